// ===== sv/mrlc_pkg.sv =====
`default_nettype none

package mrlc_pkg;

  localparam int unsigned DefaultDepth = 64;

  localparam int unsigned OpW     = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned LenOutW = 7;

  localparam logic [ByteW-1:0] ChrNewline = 8'h0A;
  localparam logic [ByteW-1:0] ChrD       = 8'h44;
  localparam logic [ByteW-1:0] ChrT       = 8'h54;
  localparam logic [ByteW-1:0] ChrN       = 8'h4E;
  localparam logic [ByteW-1:0] ChrE       = 8'h45;
  localparam logic [ByteW-1:0] ChrC       = 8'h43;
  localparam logic [ByteW-1:0] ChrO       = 8'h4F;
  localparam logic [ByteW-1:0] ChrS       = 8'h53;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RECV = 2'd1,
    ST_OVFL = 2'd2
  } status_e;

  typedef enum logic [OpW-1:0] {
    OP_RX_BYTE = 2'd0,
    OP_RESTART = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

endpackage

`default_nettype wire

// ===== sv/mrlc_ram.sv =====
`default_nettype none

module mrlc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/modem_response_line_capture_unit.sv =====
// an accepted transfer is registered in stage s1, then moves to the output stage s2 once s2 is free or not stalled
// throughput: one item per cycle when not stalled; the line buffer ram has one write and one read port
// a second item is taken while a finished result waits under stall (two-entry output pipe)
// reset (rst_ni low, async): idle status, length 0, flag clear, setup mode, pipe empty
// buffer contents are not cleared; entries past the written prefix read as zero
`default_nettype none

module modem_response_line_capture_unit
  import mrlc_pkg::*;
#(
  parameter int unsigned BufferDepth = DefaultDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_data_mode_i,

  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [OpW-1:0]     operation_i,
  input  wire logic [ByteW-1:0]   rx_byte_i,
  input  wire logic [IndexW-1:0]  read_index_i,

  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              capture_status_o,
  output logic [LenOutW-1:0]      captured_length_o,
  output logic                    connected_o,
  output logic [ByteW-1:0]        read_data_o
);

  localparam int unsigned AddrW = $clog2(BufferDepth);
  localparam int unsigned LenW  = $clog2(BufferDepth + 1);
  localparam int unsigned CmpW  = (LenW > IndexW) ? LenW : IndexW;

  logic                       data_mode_q;
  logic [LenW-1:0]            len_q, len_d;
  logic [LenW-1:0]            hw_q, hw_d;
  status_e                    status_q, status_d;
  logic                       flag_q, flag_d;
  logic [4:0][ByteW-1:0]      tail_q, tail_d;
  logic [ByteW-1:0]           last_q, last_d;

  logic                       in_acc;
  op_e                        op;
  logic                       ram_we;
  logic [AddrW-1:0]           ram_waddr;
  logic                       ram_re;
  logic [ByteW-1:0]           ram_rdata;
  logic [CmpW-1:0]            idx_ext;
  logic                       rd_zero;
  logic                       rd_last;

  logic                       s1_valid_q;
  status_e                    s1_status_q;
  logic [LenW-1:0]            s1_len_q;
  logic                       s1_flag_q;
  logic                       s1_zero_q;
  logic                       s1_use_last_q;
  logic [ByteW-1:0]           s1_last_q;
  logic                       s1_adv;

  logic                       s2_valid_q;
  status_e                    s2_status_q;
  logic [LenW-1:0]            s2_len_q;
  logic                       s2_flag_q;
  logic [ByteW-1:0]           s2_data_q;

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = !s2_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign op          = op_e'(operation_i);

  assign idx_ext = CmpW'(read_index_i);
  assign rd_zero = (op != OP_READ) || !(idx_ext < CmpW'(hw_q));
  assign rd_last = idx_ext == CmpW'(BufferDepth - 1);
  assign ram_re  = in_acc && !rd_zero && !rd_last;

  always_comb begin
    len_d     = len_q;
    hw_d      = hw_q;
    status_d  = status_q;
    flag_d    = flag_q;
    tail_d    = tail_q;
    last_d    = last_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    if (in_acc) begin
      unique case (op)
        OP_RX_BYTE: begin
          // connect / close detection on the buffered tail
          if (data_mode_q && rx_byte_i == ChrNewline && len_q >= LenW'(5) &&
              (tail_q[1] == ChrD || tail_q[1] == ChrT)) begin
            if (tail_q[4] == ChrN && tail_q[3] == ChrE && tail_q[2] == ChrC) begin
              flag_d   = 1'b1;
              len_d    = '0;
              status_d = ST_IDLE;
            end
            if (tail_q[4] == ChrO && tail_q[3] == ChrS && tail_q[2] == ChrE) begin
              flag_d   = 1'b0;
              len_d    = '0;
              status_d = ST_IDLE;
            end
          end
          if (status_d == ST_RECV) begin
            if (len_q < LenW'(BufferDepth)) begin
              if (len_q == LenW'(BufferDepth - 1)) begin
                last_d = rx_byte_i;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = len_q[AddrW-1:0];
              end
              if (len_q == hw_q) begin
                hw_d = hw_q + LenW'(1);
              end
              len_d  = len_q + LenW'(1);
              tail_d = {tail_q[3:0], rx_byte_i};
            end
            if (data_mode_q) begin
              if (len_d > LenW'(BufferDepth - 2)) begin
                status_d = ST_OVFL;
              end
            end else if (len_d > LenW'(BufferDepth - 1)) begin
              status_d = ST_IDLE;
            end
          end
          if (status_d == ST_IDLE) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            len_d     = LenW'(1);
            status_d  = ST_RECV;
            tail_d    = {tail_d[3:0], rx_byte_i};
            if (hw_d == '0) begin
              hw_d = LenW'(1);
            end
          end
        end
        OP_RESTART: begin
          len_d    = '0;
          hw_d     = '0;
          status_d = ST_IDLE;
        end
        OP_READ: begin
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  mrlc_ram #(
    .Width (ByteW),
    .Depth (BufferDepth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (idx_ext[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_mode_q <= 1'b0;
      len_q       <= '0;
      hw_q        <= '0;
      status_q    <= ST_IDLE;
      flag_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        data_mode_q <= cfg_data_mode_i;
      end
      len_q    <= len_d;
      hw_q     <= hw_d;
      status_q <= status_d;
      flag_q   <= flag_d;
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q <= tail_d;
    last_q <= last_d;
    if (in_acc) begin
      s1_status_q   <= status_d;
      s1_len_q      <= len_d;
      s1_flag_q     <= flag_d;
      s1_zero_q     <= rd_zero;
      s1_use_last_q <= rd_last;
      s1_last_q     <= last_q;
    end
    if (s1_adv && s1_valid_q) begin
      s2_status_q <= s1_status_q;
      s2_len_q    <= s1_len_q;
      s2_flag_q   <= s1_flag_q;
      if (s1_zero_q) begin
        s2_data_q <= '0;
      end else if (s1_use_last_q) begin
        s2_data_q <= s1_last_q;
      end else begin
        s2_data_q <= ram_rdata;
      end
    end
  end

  assign out_valid_o       = s2_valid_q;
  assign capture_status_o  = s2_status_q;
  assign captured_length_o = LenOutW'(s2_len_q);
  assign connected_o       = s2_flag_q;
  assign read_data_o       = s2_data_q;

`ifndef SYNTH
  a_len_within_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= hw_q) else $error("length beyond written prefix");

  a_idle_means_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q == ST_IDLE) == (len_q == '0)) else $error("idle status and length disagree");

  a_ovfl_near_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q == ST_OVFL |-> len_q >= LenW'(BufferDepth - 1))
    else $error("overflow with short buffer");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s2_valid_q) else $error("input stalled with room in pipe");
`endif

endmodule

`default_nettype wire
